// ===== rtl/tvp_pkg.sv =====
// shared widths, payload types and lane types for the transverse projection pipeline
package tvp_pkg;

    localparam int CW   = 32;           // input and output component width
    localparam int LW   = 32;           // limb width of the partial-product multipliers
    localparam int NL   = 3;            // vector lanes
    localparam int SQW  = 2 * CW;       // squares, |k|^2 and |b|^2
    localparam int DTW  = SQW + 2;      // signed dot product k.b
    localparam int VMW  = 3 * CW;       // magnitude of v = b*K - k*d
    localparam int VW   = VMW + 2;      // signed v
    localparam int VL   = VMW / LW;     // limbs of |v|
    localparam int V2W  = 2 * VMW;      // v_i^2
    localparam int V2L  = V2W / LW;     // limbs of v_i^2
    localparam int BL   = SQW / LW;     // limbs of |b|^2
    localparam int VSW  = V2W + 2;      // sum of the three v_i^2
    localparam int TPW  = V2W + SQW;    // v_i^2 * |b|^2
    localparam int TW   = TPW + 2;      // dividend, 4 * v_i^2 * |b|^2
    localparam int QW   = SQW + 2;      // quotient, never above 4 * |b|^2
    localparam int SW   = QW / 2;       // square root of the quotient
    localparam int RMW  = SW + 2;       // root remainder

    localparam int SQ_STEPS  = VL * VL;
    localparam int T_STEPS   = V2L * BL;
    localparam int FRONT_LAT = 7;
    localparam int LAT = FRONT_LAT + SQ_STEPS + T_STEPS + QW + SW + 1;

    localparam logic [SW-1:0] POS_MAX = (SW'(1) << (CW - 1)) - SW'(1);
    localparam logic [SW-1:0] NEG_MAX = SW'(1) << (CW - 1);

    typedef struct packed {
        logic signed [CW-1:0] wave_x;
        logic signed [CW-1:0] wave_y;
        logic signed [CW-1:0] wave_z;
        logic signed [CW-1:0] field_x;
        logic signed [CW-1:0] field_y;
        logic signed [CW-1:0] field_z;
    } tvp_item_t;

    typedef struct packed {
        logic signed [CW-1:0] proj_x;
        logic signed [CW-1:0] proj_y;
        logic signed [CW-1:0] proj_z;
        logic                 degenerate;
        logic                 clipped;
    } tvp_result_t;

    // sideband that rides along one lane
    typedef struct packed {
        logic degen;
        logic neg;
    } tvp_tag_t;

    typedef struct packed {
        logic [CW-1:0] proj;
        logic          clip;
        logic          degen;
    } tvp_lane_t;

endpackage

// ===== rtl/tvp_front.sv =====
// front stages: squares, dot product, residual v = b*|k|^2 - k*(k.b) and its magnitude
module tvp_front (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  tvp_pkg::tvp_item_t                          item,
    output logic                                        valid,
    output logic [tvp_pkg::NL-1:0][tvp_pkg::VMW-1:0]    vmag,
    output logic [tvp_pkg::NL-1:0]                      neg,
    output logic [tvp_pkg::SQW-1:0]                     bsum
);

    logic [tvp_pkg::FRONT_LAT-1:0] vld_reg;

    logic [tvp_pkg::NL-1:0][tvp_pkg::CW-1:0]  k0_reg, b0_reg;
    logic [tvp_pkg::NL-1:0][tvp_pkg::SQW-1:0] kk1_reg, bb1_reg, kb1_reg;
    logic [tvp_pkg::NL-1:0][tvp_pkg::SQW-1:0] kk1_next, bb1_next, kb1_next;
    logic [tvp_pkg::NL-1:0][tvp_pkg::CW-1:0]  k1_reg, b1_reg, k2_reg, b2_reg;
    logic [tvp_pkg::SQW-1:0]                  ksum2_reg, bsum2_reg, dmag2_reg;
    logic [tvp_pkg::SQW-1:0]                  ksum2_next, bsum2_next, dmag2_next;
    logic                                     dneg2_reg, dneg2_next;
    logic [tvp_pkg::NL-1:0][tvp_pkg::SQW-1:0] pb_lo3_reg, pb_hi3_reg, pk_lo3_reg, pk_hi3_reg;
    logic [tvp_pkg::NL-1:0][tvp_pkg::SQW-1:0] pb_lo3_next, pb_hi3_next, pk_lo3_next, pk_hi3_next;
    logic [tvp_pkg::NL-1:0]                   sb3_reg, sk3_reg, sb3_next, sk3_next;
    logic [tvp_pkg::SQW-1:0]                  bsum3_reg, bsum4_reg, bsum5_reg, bsum6_reg;
    logic [tvp_pkg::NL-1:0][tvp_pkg::VMW-1:0] bk4_reg, kd4_reg, bk4_next, kd4_next;
    logic [tvp_pkg::NL-1:0]                   sb4_reg, sk4_reg;
    logic [tvp_pkg::NL-1:0][tvp_pkg::VW-1:0]  v5_reg, v5_next;
    logic [tvp_pkg::NL-1:0][tvp_pkg::VMW-1:0] vmag6_reg, vmag6_next;
    logic [tvp_pkg::NL-1:0]                   neg6_reg, neg6_next;

    // stage 1: per-lane squares and cross products
    always_comb
    begin
        logic signed [tvp_pkg::SQW-1:0] pk, pb, px;
        for (int i = 0; i < tvp_pkg::NL; i++)
        begin
            pk = tvp_pkg::SQW'($signed(k0_reg[i])) * tvp_pkg::SQW'($signed(k0_reg[i]));
            pb = tvp_pkg::SQW'($signed(b0_reg[i])) * tvp_pkg::SQW'($signed(b0_reg[i]));
            px = tvp_pkg::SQW'($signed(k0_reg[i])) * tvp_pkg::SQW'($signed(b0_reg[i]));
            kk1_next[i] = pk;
            bb1_next[i] = pb;
            kb1_next[i] = px;
        end
    end

    // stage 2: |k|^2, |b|^2 and the magnitude of k.b
    always_comb
    begin
        logic [tvp_pkg::DTW-1:0] dsum, dabs;
        ksum2_next = kk1_reg[0] + kk1_reg[1] + kk1_reg[2];
        bsum2_next = bb1_reg[0] + bb1_reg[1] + bb1_reg[2];
        dsum = {{2{kb1_reg[0][tvp_pkg::SQW-1]}}, kb1_reg[0]}
             + {{2{kb1_reg[1][tvp_pkg::SQW-1]}}, kb1_reg[1]}
             + {{2{kb1_reg[2][tvp_pkg::SQW-1]}}, kb1_reg[2]};
        dabs = dsum[tvp_pkg::DTW-1] ? (~dsum + tvp_pkg::DTW'(1)) : dsum;
        dneg2_next = dsum[tvp_pkg::DTW-1];
        dmag2_next = dabs[tvp_pkg::SQW-1:0];
    end

    // stage 3: 32x32 partial products of |b_i|*K and |k_i|*|d|
    always_comb
    begin
        logic [tvp_pkg::CW-1:0] km, bm;
        for (int i = 0; i < tvp_pkg::NL; i++)
        begin
            km = k2_reg[i][tvp_pkg::CW-1] ? (~k2_reg[i] + tvp_pkg::CW'(1)) : k2_reg[i];
            bm = b2_reg[i][tvp_pkg::CW-1] ? (~b2_reg[i] + tvp_pkg::CW'(1)) : b2_reg[i];
            pb_lo3_next[i] = tvp_pkg::SQW'(bm) * tvp_pkg::SQW'(ksum2_reg[tvp_pkg::LW-1:0]);
            pb_hi3_next[i] = tvp_pkg::SQW'(bm) * tvp_pkg::SQW'(ksum2_reg[tvp_pkg::SQW-1:tvp_pkg::LW]);
            pk_lo3_next[i] = tvp_pkg::SQW'(km) * tvp_pkg::SQW'(dmag2_reg[tvp_pkg::LW-1:0]);
            pk_hi3_next[i] = tvp_pkg::SQW'(km) * tvp_pkg::SQW'(dmag2_reg[tvp_pkg::SQW-1:tvp_pkg::LW]);
            sb3_next[i] = b2_reg[i][tvp_pkg::CW-1];
            sk3_next[i] = k2_reg[i][tvp_pkg::CW-1] ^ dneg2_reg;
        end
    end

    // stage 4: join the partial products
    always_comb
    begin
        for (int i = 0; i < tvp_pkg::NL; i++)
        begin
            bk4_next[i] = tvp_pkg::VMW'(pb_lo3_reg[i])
                        + (tvp_pkg::VMW'(pb_hi3_reg[i]) << tvp_pkg::LW);
            kd4_next[i] = tvp_pkg::VMW'(pk_lo3_reg[i])
                        + (tvp_pkg::VMW'(pk_hi3_reg[i]) << tvp_pkg::LW);
        end
    end

    // stage 5: signed difference
    always_comb
    begin
        logic [tvp_pkg::VW-1:0] x, y;
        for (int i = 0; i < tvp_pkg::NL; i++)
        begin
            x = {2'b00, bk4_reg[i]};
            y = {2'b00, kd4_reg[i]};
            if (sb4_reg[i])
            begin
                x = ~x + tvp_pkg::VW'(1);
            end
            if (sk4_reg[i])
            begin
                y = ~y + tvp_pkg::VW'(1);
            end
            v5_next[i] = x - y;
        end
    end

    // stage 6: magnitude and sign of v
    always_comb
    begin
        logic [tvp_pkg::VW-1:0] a;
        for (int i = 0; i < tvp_pkg::NL; i++)
        begin
            a = v5_reg[i][tvp_pkg::VW-1] ? (~v5_reg[i] + tvp_pkg::VW'(1)) : v5_reg[i];
            vmag6_next[i] = a[tvp_pkg::VMW-1:0];
            neg6_next[i] = v5_reg[i][tvp_pkg::VW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[tvp_pkg::FRONT_LAT-2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        k0_reg    <= {item.wave_z, item.wave_y, item.wave_x};
        b0_reg    <= {item.field_z, item.field_y, item.field_x};
        kk1_reg   <= kk1_next;
        bb1_reg   <= bb1_next;
        kb1_reg   <= kb1_next;
        k1_reg    <= k0_reg;
        b1_reg    <= b0_reg;
        ksum2_reg <= ksum2_next;
        bsum2_reg <= bsum2_next;
        dmag2_reg <= dmag2_next;
        dneg2_reg <= dneg2_next;
        k2_reg    <= k1_reg;
        b2_reg    <= b1_reg;
        pb_lo3_reg <= pb_lo3_next;
        pb_hi3_reg <= pb_hi3_next;
        pk_lo3_reg <= pk_lo3_next;
        pk_hi3_reg <= pk_hi3_next;
        sb3_reg   <= sb3_next;
        sk3_reg   <= sk3_next;
        bsum3_reg <= bsum2_reg;
        bk4_reg   <= bk4_next;
        kd4_reg   <= kd4_next;
        sb4_reg   <= sb3_reg;
        sk4_reg   <= sk3_reg;
        bsum4_reg <= bsum3_reg;
        v5_reg    <= v5_next;
        bsum5_reg <= bsum4_reg;
        vmag6_reg <= vmag6_next;
        neg6_reg  <= neg6_next;
        bsum6_reg <= bsum5_reg;
    end

    assign valid = vld_reg[tvp_pkg::FRONT_LAT-1];
    assign vmag  = vmag6_reg;
    assign neg   = neg6_reg;
    assign bsum  = bsum6_reg;

endmodule

// ===== rtl/tvp_sq.sv =====
// limb-serial multiply stages: v_i^2, their sum, then v_i^2 * |b|^2
module tvp_sq (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  logic [tvp_pkg::NL-1:0][tvp_pkg::VMW-1:0]    vmag,
    input  logic [tvp_pkg::NL-1:0]                      neg_in,
    input  logic [tvp_pkg::SQW-1:0]                     bsum,
    output logic                                        out_valid,
    output logic [tvp_pkg::NL-1:0]                      neg_out,
    output logic [tvp_pkg::VSW-1:0]                     vsum,
    output logic [tvp_pkg::NL-1:0][tvp_pkg::TPW-1:0]    prod
);

    typedef struct packed {
        logic [tvp_pkg::NL-1:0]                   neg;
        logic [tvp_pkg::NL-1:0][tvp_pkg::VMW-1:0] vmag;
        logic [tvp_pkg::SQW-1:0]                  bsum;
        logic [tvp_pkg::NL-1:0][tvp_pkg::V2W-1:0] acc;
    } sqa_t;

    typedef struct packed {
        logic [tvp_pkg::NL-1:0]                   neg;
        logic [tvp_pkg::NL-1:0][tvp_pkg::V2W-1:0] v2;
        logic [tvp_pkg::SQW-1:0]                  bsum;
        logic [tvp_pkg::VSW-1:0]                  vs;
        logic [tvp_pkg::NL-1:0][tvp_pkg::TPW-1:0] acc;
    } sqb_t;

    sqa_t                           a_reg [tvp_pkg::SQ_STEPS];
    logic [tvp_pkg::SQ_STEPS-1:0]   a_vld_reg;
    sqb_t                           b_reg [tvp_pkg::T_STEPS];
    logic [tvp_pkg::T_STEPS-1:0]    b_vld_reg;
    sqa_t                           head_a;
    sqb_t                           head_b;

    always_comb
    begin
        head_a.neg  = neg_in;
        head_a.vmag = vmag;
        head_a.bsum = bsum;
        head_a.acc  = '0;
    end

    // one 32x32 limb product per lane per stage
    for (genvar s = 0; s < tvp_pkg::SQ_STEPS; s++)
    begin : g_sq
        localparam int LI = s / tvp_pkg::VL;
        localparam int LJ = s % tvp_pkg::VL;
        sqa_t src, nxt;
        logic src_vld;

        if (s == 0)
        begin : g_head
            assign src = head_a;
            assign src_vld = in_valid;
        end
        else
        begin : g_tail
            assign src = a_reg[s-1];
            assign src_vld = a_vld_reg[s-1];
        end

        always_comb
        begin
            logic [2*tvp_pkg::LW-1:0] pp;
            nxt = src;
            for (int l = 0; l < tvp_pkg::NL; l++)
            begin
                pp = tvp_pkg::SQW'(src.vmag[l][LI*tvp_pkg::LW +: tvp_pkg::LW])
                   * tvp_pkg::SQW'(src.vmag[l][LJ*tvp_pkg::LW +: tvp_pkg::LW]);
                nxt.acc[l] = src.acc[l]
                           + ({{(tvp_pkg::V2W-2*tvp_pkg::LW){1'b0}}, pp} << (tvp_pkg::LW*(LI+LJ)));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_vld_reg[s] <= 1'b0;
            end
            else
            begin
                a_vld_reg[s] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            a_reg[s] <= nxt;
        end
    end

    // squared length of v, formed alongside the first product stage
    always_comb
    begin
        head_b.neg  = a_reg[tvp_pkg::SQ_STEPS-1].neg;
        head_b.v2   = a_reg[tvp_pkg::SQ_STEPS-1].acc;
        head_b.bsum = a_reg[tvp_pkg::SQ_STEPS-1].bsum;
        head_b.vs   = {2'b00, a_reg[tvp_pkg::SQ_STEPS-1].acc[0]}
                    + {2'b00, a_reg[tvp_pkg::SQ_STEPS-1].acc[1]}
                    + {2'b00, a_reg[tvp_pkg::SQ_STEPS-1].acc[2]};
        head_b.acc  = '0;
    end

    for (genvar s = 0; s < tvp_pkg::T_STEPS; s++)
    begin : g_t
        localparam int LI = s / tvp_pkg::BL;
        localparam int LJ = s % tvp_pkg::BL;
        sqb_t src, nxt;
        logic src_vld;

        if (s == 0)
        begin : g_head
            assign src = head_b;
            assign src_vld = a_vld_reg[tvp_pkg::SQ_STEPS-1];
        end
        else
        begin : g_tail
            assign src = b_reg[s-1];
            assign src_vld = b_vld_reg[s-1];
        end

        always_comb
        begin
            logic [2*tvp_pkg::LW-1:0] pp;
            nxt = src;
            for (int l = 0; l < tvp_pkg::NL; l++)
            begin
                pp = tvp_pkg::SQW'(src.v2[l][LI*tvp_pkg::LW +: tvp_pkg::LW])
                   * tvp_pkg::SQW'(src.bsum[LJ*tvp_pkg::LW +: tvp_pkg::LW]);
                nxt.acc[l] = src.acc[l]
                           + ({{(tvp_pkg::TPW-2*tvp_pkg::LW){1'b0}}, pp} << (tvp_pkg::LW*(LI+LJ)));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                b_vld_reg[s] <= 1'b0;
            end
            else
            begin
                b_vld_reg[s] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            b_reg[s] <= nxt;
        end
    end

    assign out_valid = b_vld_reg[tvp_pkg::T_STEPS-1];
    assign neg_out   = b_reg[tvp_pkg::T_STEPS-1].neg;
    assign vsum      = b_reg[tvp_pkg::T_STEPS-1].vs;
    assign prod      = b_reg[tvp_pkg::T_STEPS-1].acc;

endmodule

// ===== rtl/tvp_div.sv =====
// restoring divider for one lane, one quotient bit per stage
module tvp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  tvp_pkg::tvp_tag_t           tag_in,
    input  logic [tvp_pkg::TW-1:0]      num,
    input  logic [tvp_pkg::VSW-1:0]     den,
    output logic                        out_valid,
    output tvp_pkg::tvp_tag_t           tag_out,
    output logic [tvp_pkg::QW-1:0]      quot
);

    typedef struct packed {
        tvp_pkg::tvp_tag_t          tag;
        logic [tvp_pkg::VSW-1:0]    rem;
        logic [tvp_pkg::QW-1:0]     low;
        logic [tvp_pkg::VSW-1:0]    den;
        logic [tvp_pkg::QW-1:0]     q;
    } dv_t;

    dv_t                        st_reg [tvp_pkg::QW];
    logic [tvp_pkg::QW-1:0]     vld_reg;
    dv_t                        head;

    // quotient stays below 2^QW, so the top bits start out below the divisor
    always_comb
    begin
        head.tag = tag_in;
        head.rem = tvp_pkg::VSW'(num[tvp_pkg::TW-1:tvp_pkg::QW]);
        head.low = num[tvp_pkg::QW-1:0];
        head.den = den;
        head.q   = '0;
    end

    for (genvar s = 0; s < tvp_pkg::QW; s++)
    begin : g_st
        dv_t src, nxt;
        logic src_vld;

        if (s == 0)
        begin : g_head
            assign src = head;
            assign src_vld = in_valid;
        end
        else
        begin : g_tail
            assign src = st_reg[s-1];
            assign src_vld = vld_reg[s-1];
        end

        always_comb
        begin
            logic [tvp_pkg::VSW:0]   r2;
            logic [tvp_pkg::VSW+1:0] diff;
            logic                    ge;
            r2   = {src.rem, src.low[tvp_pkg::QW-1]};
            diff = {1'b0, r2} - {2'b00, src.den};
            ge   = ~diff[tvp_pkg::VSW+1];
            nxt  = src;
            nxt.rem = ge ? diff[tvp_pkg::VSW-1:0] : r2[tvp_pkg::VSW-1:0];
            nxt.low = {src.low[tvp_pkg::QW-2:0], 1'b0};
            nxt.q   = {src.q[tvp_pkg::QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[s] <= nxt;
        end
    end

    assign out_valid = vld_reg[tvp_pkg::QW-1];
    assign tag_out   = st_reg[tvp_pkg::QW-1].tag;
    assign quot      = st_reg[tvp_pkg::QW-1].q;

endmodule

// ===== rtl/tvp_root.sv =====
// digit-by-digit square root for one lane, then round, sign and saturate
module tvp_root (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  tvp_pkg::tvp_tag_t           tag_in,
    input  logic [tvp_pkg::QW-1:0]      rad,
    output logic                        out_valid,
    output tvp_pkg::tvp_lane_t          lane
);

    typedef struct packed {
        tvp_pkg::tvp_tag_t          tag;
        logic [tvp_pkg::QW-1:0]     rad;
        logic [tvp_pkg::RMW-1:0]    rem;
        logic [tvp_pkg::SW-1:0]     root;
    } rt_t;

    rt_t                        st_reg [tvp_pkg::SW];
    logic [tvp_pkg::SW-1:0]     vld_reg;
    rt_t                        head;
    tvp_pkg::tvp_lane_t         lane_reg, lane_next;
    logic                       out_vld_reg;

    always_comb
    begin
        head.tag  = tag_in;
        head.rad  = rad;
        head.rem  = '0;
        head.root = '0;
    end

    for (genvar s = 0; s < tvp_pkg::SW; s++)
    begin : g_st
        rt_t src, nxt;
        logic src_vld;

        if (s == 0)
        begin : g_head
            assign src = head;
            assign src_vld = in_valid;
        end
        else
        begin : g_tail
            assign src = st_reg[s-1];
            assign src_vld = vld_reg[s-1];
        end

        always_comb
        begin
            logic [tvp_pkg::RMW+1:0] r4, trial, diff;
            logic                    ge;
            r4    = {src.rem, src.rad[tvp_pkg::QW-1 -: 2]};
            trial = {2'b00, src.root, 2'b01};
            diff  = r4 - trial;
            ge    = (r4 >= trial);
            nxt   = src;
            nxt.rem  = ge ? diff[tvp_pkg::RMW-1:0] : r4[tvp_pkg::RMW-1:0];
            nxt.root = {src.root[tvp_pkg::SW-2:0], ge};
            nxt.rad  = {src.rad[tvp_pkg::QW-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[s] <= nxt;
        end
    end

    // largest n with (2n-1)^2 <= q is (isqrt(q)+1)/2
    always_comb
    begin
        logic [tvp_pkg::SW:0]   s1;
        logic [tvp_pkg::SW-1:0] n, cap;
        logic                   over;
        logic [tvp_pkg::CW-1:0] m;
        s1   = {1'b0, st_reg[tvp_pkg::SW-1].root} + (tvp_pkg::SW+1)'(1);
        n    = s1[tvp_pkg::SW:1];
        cap  = st_reg[tvp_pkg::SW-1].tag.neg ? tvp_pkg::NEG_MAX : tvp_pkg::POS_MAX;
        over = (n > cap);
        m    = over ? cap[tvp_pkg::CW-1:0] : n[tvp_pkg::CW-1:0];
        lane_next.degen = st_reg[tvp_pkg::SW-1].tag.degen;
        if (st_reg[tvp_pkg::SW-1].tag.degen)
        begin
            lane_next.proj = '0;
            lane_next.clip = 1'b0;
        end
        else
        begin
            lane_next.proj = st_reg[tvp_pkg::SW-1].tag.neg ? (~m + tvp_pkg::CW'(1)) : m;
            lane_next.clip = over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[tvp_pkg::SW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign out_valid = out_vld_reg;
    assign lane      = lane_reg;

endmodule

// ===== rtl/transverse_vector_projection.sv =====
// throughput: one vector pair per cycle, busy is never raised and the receiver cannot stall
// depth is set by the 66-stage quotient divider and the 33-stage square root, one bit a stage
// multiplies run one 32x32 limb product per stage per lane (9 stages for v^2, 12 for v^2*|b|^2)
// reset clears all valid bits at once; nothing in flight survives it, no clearing pass
// top level: front, multiply stages, then per-lane divider and root, result assembly
module transverse_vector_projection (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  tvp_pkg::tvp_item_t      item,
    output logic                    done,
    output tvp_pkg::tvp_result_t    result
);

    logic                                       f_valid;
    logic [tvp_pkg::NL-1:0][tvp_pkg::VMW-1:0]   f_vmag;
    logic [tvp_pkg::NL-1:0]                     f_neg;
    logic [tvp_pkg::SQW-1:0]                    f_bsum;

    logic                                       s_valid;
    logic [tvp_pkg::NL-1:0]                     s_neg;
    logic [tvp_pkg::VSW-1:0]                    s_vsum;
    logic [tvp_pkg::NL-1:0][tvp_pkg::TPW-1:0]   s_prod;
    logic                                       s_degen;

    logic [tvp_pkg::NL-1:0]                     d_valid;
    tvp_pkg::tvp_tag_t                          d_tag [tvp_pkg::NL];
    logic [tvp_pkg::QW-1:0]                     d_quot [tvp_pkg::NL];

    logic [tvp_pkg::NL-1:0]                     r_valid;
    tvp_pkg::tvp_lane_t                         r_lane [tvp_pkg::NL];

    assign busy = 1'b0;

    tvp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start & ~busy),
        .item  (item),
        .valid (f_valid),
        .vmag  (f_vmag),
        .neg   (f_neg),
        .bsum  (f_bsum)
    );

    tvp_sq u_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .vmag      (f_vmag),
        .neg_in    (f_neg),
        .bsum      (f_bsum),
        .out_valid (s_valid),
        .neg_out   (s_neg),
        .vsum      (s_vsum),
        .prod      (s_prod)
    );

    // zero k, zero b and b parallel to k all leave v at zero
    assign s_degen = (s_vsum == '0);

    for (genvar l = 0; l < tvp_pkg::NL; l++)
    begin : g_lane
        tvp_pkg::tvp_tag_t tag;

        assign tag.degen = s_degen;
        assign tag.neg   = s_neg[l];

        tvp_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s_valid),
            .tag_in    (tag),
            .num       ({s_prod[l], 2'b00}),
            .den       (s_vsum),
            .out_valid (d_valid[l]),
            .tag_out   (d_tag[l]),
            .quot      (d_quot[l])
        );

        tvp_root u_root (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (d_valid[l]),
            .tag_in    (d_tag[l]),
            .rad       (d_quot[l]),
            .out_valid (r_valid[l]),
            .lane      (r_lane[l])
        );
    end

    assign done              = &r_valid;
    assign result.proj_x     = r_lane[0].proj;
    assign result.proj_y     = r_lane[1].proj;
    assign result.proj_z     = r_lane[2].proj;
    assign result.degenerate = r_lane[0].degen & r_lane[1].degen & r_lane[2].degen;
    assign result.clipped    = r_lane[0].clip | r_lane[1].clip | r_lane[2].clip;

endmodule

// ===== rtl/tvp_chk.sv =====
// port-level checks for the transverse projection block, bound to the top level
module tvp_chk (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  tvp_pkg::tvp_item_t      item,
    input  logic                    done,
    input  tvp_pkg::tvp_result_t    result
);

    // every result beat traces back to a start taken a fixed time before
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, tvp_pkg::LAT))
        else $error("result beat without matching start");

    a_zero_wave : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.wave_x == '0 && item.wave_y == '0 && item.wave_z == '0)
        |-> ##(tvp_pkg::LAT) (done && result.degenerate))
        else $error("zero wave vector not flagged");

    a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.degenerate) |->
        (result.proj_x == '0 && result.proj_y == '0 && result.proj_z == '0 && !result.clipped))
        else $error("degenerate result not zero");

    a_clip_rail : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.clipped) |->
        (result.proj_x == 32'h7fffffff || result.proj_x == 32'h80000000 ||
         result.proj_y == 32'h7fffffff || result.proj_y == 32'h80000000 ||
         result.proj_z == 32'h7fffffff || result.proj_z == 32'h80000000))
        else $error("clipped set without a saturated component");

endmodule

bind transverse_vector_projection tvp_chk u_tvp_chk (.*);
